// ===== hw/rtl/dart_throwing_min_distance_filter_unit_assert.svh =====
// assertion macros for the filter unit rtl
`ifndef DART_THROWING_MIN_DISTANCE_FILTER_UNIT_ASSERT_SVH
`define DART_THROWING_MIN_DISTANCE_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DTMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DTMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dtmd_pkg.sv =====
package dtmd_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int COORD_BITS_DEF  = 24;

    localparam int THR_W   = 52;
    localparam int QUOTA_W = 11;
    localparam int INDEX_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [QUOTA_W-1:0] QUOTA_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DIST_SQ  = 1'b0,
        CFG_ACCEPT_QUOTA = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        REQ_START     = 2'd0,
        REQ_PRELOAD   = 2'd1,
        REQ_CANDIDATE = 2'd2,
        REQ_UNUSED    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        OUT_ACCEPTED  = 3'd0,
        OUT_TOO_CLOSE = 3'd1,
        OUT_QUOTA     = 3'd2,
        OUT_PRELOADED = 3'd3,
        OUT_FULL      = 3'd4,
        OUT_CLEARED   = 3'd5
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_RESP  = 3'b100
    } state_t;

endpackage

// ===== hw/rtl/dtmd_in_if.sv =====
interface dtmd_in_if #(
    parameter int COORD_BITS = dtmd_pkg::COORD_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [1:0]                         req_type;
    logic [dtmd_pkg::INDEX_W-1:0]       cand_index;
    logic signed [COORD_BITS-1:0]       pos_x;
    logic signed [COORD_BITS-1:0]       pos_y;
    logic signed [COORD_BITS-1:0]       pos_z;

    modport source (output valid, req_type, cand_index, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, req_type, cand_index, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== hw/rtl/dtmd_out_if.sv =====
interface dtmd_out_if;
    logic                               valid;
    logic                               ready;
    logic [2:0]                         outcome;
    logic [dtmd_pkg::INDEX_W-1:0]       out_index;
    logic [dtmd_pkg::QUOTA_W-1:0]       accepted_total;

    modport source (output valid, outcome, out_index, accepted_total, input ready);
    modport sink   (input valid, outcome, out_index, accepted_total, output ready);
endinterface

// ===== hw/rtl/dtmd_cfg_if.sv =====
interface dtmd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dtmd_pkg::CFG_IDX_W-1:0]     index;
    logic [dtmd_pkg::THR_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dart_throwing_min_distance_filter_unit.sv =====
// flow: start and preload words go from ST_IDLE straight to ST_RESP and the result word;
// a candidate under quota first sweeps through the cell chain in ST_SWEEP
// throughput: one word at a time, set by the sweep of the candidate through the cell chain
// a quota-reached candidate skips the sweep like start and preload
// reset: rst_n async active low clears counts, state, output valid and cell flags; min_dist_sq to 0,
// accept_quota to 1024; stored points are undefined until written
`include "dart_throwing_min_distance_filter_unit_assert.svh"

module dart_throwing_min_distance_filter_unit #(
    parameter int STORE_DEPTH = dtmd_pkg::STORE_DEPTH_DEF,
    parameter int COORD_BITS  = dtmd_pkg::COORD_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    dtmd_in_if.sink      in,
    dtmd_out_if.source   out,
    dtmd_cfg_if.sink     cfg
);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int SQ_W   = 2 * COORD_BITS + 2;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > dtmd_pkg::THR_W) ? SUM_W : dtmd_pkg::THR_W;
    localparam int SWP_W  = $clog2(STORE_DEPTH + 1);
    localparam int QW     = dtmd_pkg::QUOTA_W;
    localparam int IW     = dtmd_pkg::INDEX_W;

    // configuration
    logic [dtmd_pkg::THR_W-1:0] min_dist_sq_reg;
    logic [QW-1:0]              accept_quota_reg;

    // control
    dtmd_pkg::state_t           state_reg, state_next;
    logic [CNT_W-1:0]           stored_cnt_reg, stored_cnt_next;
    logic [QW-1:0]              accept_cnt_reg, accept_cnt_next;
    logic [SWP_W-1:0]           sweep_cnt_reg, sweep_cnt_next;
    logic                       out_valid_reg, out_valid_next;

    // payload
    logic signed [COORD_BITS-1:0] cand_x_reg, cand_y_reg, cand_z_reg;
    logic [IW-1:0]              idx_reg;
    logic [2:0]                 res_outcome_reg, res_outcome_next;
    logic [2:0]                 out_outcome_reg;
    logic [IW-1:0]              out_index_reg;
    logic [QW-1:0]              out_total_reg;

    logic                       in_fire;
    logic                       store_en;
    logic                       full;
    logic                       final_close;
    logic [CMP_W-1:0]           thr;

    // chain taps: element k feeds cell k
    logic signed [COORD_BITS-1:0] tx [STORE_DEPTH+1];
    logic signed [COORD_BITS-1:0] ty [STORE_DEPTH+1];
    logic signed [COORD_BITS-1:0] tz [STORE_DEPTH+1];
    logic                         tclose [STORE_DEPTH+1];
    logic                         tpend  [STORE_DEPTH+1];
    logic [SQ_W-1:0]              tsqx [STORE_DEPTH+1];
    logic [SQ_W-1:0]              tsqy [STORE_DEPTH+1];
    logic [SQ_W-1:0]              tsqz [STORE_DEPTH+1];
    logic [CMP_W-1:0]             last_sum;

    assign in.ready  = (state_reg == dtmd_pkg::ST_IDLE);
    assign in_fire   = in.valid & in.ready;
    assign cfg.ready = 1'b1;
    assign full      = (stored_cnt_reg == CNT_W'(STORE_DEPTH));
    assign thr       = CMP_W'(min_dist_sq_reg);

    // head of the chain: held candidate, nothing pending
    assign tx[0]     = cand_x_reg;
    assign ty[0]     = cand_y_reg;
    assign tz[0]     = cand_z_reg;
    assign tclose[0] = 1'b0;
    assign tpend[0]  = 1'b0;
    assign tsqx[0]   = '0;
    assign tsqy[0]   = '0;
    assign tsqz[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++)
        begin : g_cell
            dtmd_cell #(
                .COORD_BITS (COORD_BITS),
                .SQ_W       (SQ_W),
                .CMP_W      (CMP_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (store_en && (stored_cnt_reg == CNT_W'(gi))),
                .active    (CNT_W'(gi) < stored_cnt_reg),
                .thr       (thr),
                .wx_in     (cand_x_reg),
                .wy_in     (cand_y_reg),
                .wz_in     (cand_z_reg),
                .cx_in     (tx[gi]),
                .cy_in     (ty[gi]),
                .cz_in     (tz[gi]),
                .close_in  (tclose[gi]),
                .pend_in   (tpend[gi]),
                .sqx_in    (tsqx[gi]),
                .sqy_in    (tsqy[gi]),
                .sqz_in    (tsqz[gi]),
                .cx_out    (tx[gi+1]),
                .cy_out    (ty[gi+1]),
                .cz_out    (tz[gi+1]),
                .close_out (tclose[gi+1]),
                .pend_out  (tpend[gi+1]),
                .sqx_out   (tsqx[gi+1]),
                .sqy_out   (tsqy[gi+1]),
                .sqz_out   (tsqz[gi+1])
            );
        end
    endgenerate

    // tail of the chain: fold in the last cell's squares
    assign last_sum = CMP_W'(tsqx[STORE_DEPTH]) + CMP_W'(tsqy[STORE_DEPTH])
                    + CMP_W'(tsqz[STORE_DEPTH]);
    assign final_close = tclose[STORE_DEPTH] | (tpend[STORE_DEPTH] & (last_sum < thr));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_sq_reg  <= '0;
            accept_quota_reg <= dtmd_pkg::QUOTA_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (dtmd_pkg::cfg_reg_t'(cfg.index))
                dtmd_pkg::CFG_MIN_DIST_SQ:  min_dist_sq_reg  <= cfg.data;
                dtmd_pkg::CFG_ACCEPT_QUOTA: accept_quota_reg <= cfg.data[QW-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        stored_cnt_next  = stored_cnt_reg;
        accept_cnt_next  = accept_cnt_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        out_valid_next   = out_valid_reg;
        res_outcome_next = res_outcome_reg;
        store_en         = 1'b0;

        if (out_valid_reg && out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dtmd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (dtmd_pkg::req_t'(in.req_type))
                        dtmd_pkg::REQ_START:
                        begin
                            stored_cnt_next  = '0;
                            accept_cnt_next  = '0;
                            res_outcome_next = dtmd_pkg::OUT_CLEARED;
                            state_next       = dtmd_pkg::ST_RESP;
                        end
                        dtmd_pkg::REQ_PRELOAD:
                        begin
                            res_outcome_next = full ? dtmd_pkg::OUT_FULL
                                                    : dtmd_pkg::OUT_PRELOADED;
                            state_next       = dtmd_pkg::ST_RESP;
                        end
                        dtmd_pkg::REQ_CANDIDATE:
                        begin
                            if (accept_cnt_reg >= accept_quota_reg)
                            begin
                                res_outcome_next = dtmd_pkg::OUT_QUOTA;
                                state_next       = dtmd_pkg::ST_RESP;
                            end
                            else
                            begin
                                sweep_cnt_next = '0;
                                state_next     = dtmd_pkg::ST_SWEEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dtmd_pkg::ST_SWEEP:
            begin
                if (sweep_cnt_reg == SWP_W'(STORE_DEPTH))
                begin
                    if (final_close)
                    begin
                        res_outcome_next = dtmd_pkg::OUT_TOO_CLOSE;
                    end
                    else if (full)
                    begin
                        res_outcome_next = dtmd_pkg::OUT_FULL;
                    end
                    else
                    begin
                        res_outcome_next = dtmd_pkg::OUT_ACCEPTED;
                    end
                    state_next = dtmd_pkg::ST_RESP;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + SWP_W'(1);
                end
            end
            dtmd_pkg::ST_RESP:
            begin
                // write the point held in the candidate registers when preloaded or accepted, and post the word
                if (!out_valid_reg || out.ready)
                begin
                    if (res_outcome_reg == dtmd_pkg::OUT_PRELOADED
                        || res_outcome_reg == dtmd_pkg::OUT_ACCEPTED)
                    begin
                        store_en        = 1'b1;
                        stored_cnt_next = stored_cnt_reg + CNT_W'(1);
                    end
                    if (res_outcome_reg == dtmd_pkg::OUT_ACCEPTED)
                    begin
                        accept_cnt_next = accept_cnt_reg + QW'(1);
                    end
                    out_valid_next = 1'b1;
                    state_next     = dtmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtmd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dtmd_pkg::ST_IDLE;
            stored_cnt_reg <= '0;
            accept_cnt_reg <= '0;
            sweep_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            stored_cnt_reg <= stored_cnt_next;
            accept_cnt_reg <= accept_cnt_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_outcome_reg <= res_outcome_next;
        if (in_fire)
        begin
            cand_x_reg <= in.pos_x;
            cand_y_reg <= in.pos_y;
            cand_z_reg <= in.pos_z;
            idx_reg    <= in.cand_index;
        end
        if (state_reg == dtmd_pkg::ST_RESP && (!out_valid_reg || out.ready))
        begin
            out_outcome_reg <= res_outcome_reg;
            out_index_reg   <= idx_reg;
            out_total_reg   <= accept_cnt_next;
        end
    end

    assign out.valid          = out_valid_reg;
    assign out.outcome        = out_outcome_reg;
    assign out.out_index      = out_index_reg;
    assign out.accepted_total = out_total_reg;

    `DTMD_ASSERT_NOW(a_count_in_range, 1'b1, stored_cnt_reg <= CNT_W'(STORE_DEPTH), "store count beyond depth")
    `DTMD_ASSERT_NOW(a_accept_le_stored, 1'b1, CMP_W'(accept_cnt_reg) <= CMP_W'(stored_cnt_reg), "more acceptances than stored points")
    `DTMD_ASSERT_NEXT(a_sweep_start, in_fire && in.req_type == dtmd_pkg::REQ_CANDIDATE && accept_cnt_reg < accept_quota_reg, state_reg == dtmd_pkg::ST_SWEEP && sweep_cnt_reg == '0, "candidate did not start a sweep")
    `DTMD_ASSERT_NEXT(a_sweep_fixed, state_reg == dtmd_pkg::ST_SWEEP, $stable(stored_cnt_reg) && $stable(cand_x_reg), "state changed during sweep")
endmodule

// ===== hw/rtl/dtmd_cell.sv =====
// one stored point; checks the squares handed in by the left neighbor and
// forms its own squares against the passing candidate
module dtmd_cell #(
    parameter int COORD_BITS = dtmd_pkg::COORD_BITS_DEF,
    parameter int SQ_W       = 2 * COORD_BITS + 2,
    parameter int CMP_W      = 2 * COORD_BITS + 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        active,
    input  logic [CMP_W-1:0]            thr,
    input  logic signed [COORD_BITS-1:0] wx_in,
    input  logic signed [COORD_BITS-1:0] wy_in,
    input  logic signed [COORD_BITS-1:0] wz_in,
    input  logic signed [COORD_BITS-1:0] cx_in,
    input  logic signed [COORD_BITS-1:0] cy_in,
    input  logic signed [COORD_BITS-1:0] cz_in,
    input  logic                        close_in,
    input  logic                        pend_in,
    input  logic [SQ_W-1:0]             sqx_in,
    input  logic [SQ_W-1:0]             sqy_in,
    input  logic [SQ_W-1:0]             sqz_in,
    output logic signed [COORD_BITS-1:0] cx_out,
    output logic signed [COORD_BITS-1:0] cy_out,
    output logic signed [COORD_BITS-1:0] cz_out,
    output logic                        close_out,
    output logic                        pend_out,
    output logic [SQ_W-1:0]             sqx_out,
    output logic [SQ_W-1:0]             sqy_out,
    output logic [SQ_W-1:0]             sqz_out
);
    localparam int D_W = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;
    logic [SQ_W-1:0]              sqx_reg, sqy_reg, sqz_reg;
    logic                         close_reg, pend_reg;
    logic                         close_next;
    logic [CMP_W-1:0]             sum;
    logic signed [D_W-1:0]        dx, dy, dz;
    logic [D_W-1:0]               mx, my, mz;

    // distance to the previous cell's point
    assign sum = CMP_W'(sqx_in) + CMP_W'(sqy_in) + CMP_W'(sqz_in);
    assign close_next = close_in | (pend_in & (sum < thr));

    assign dx = D_W'(cx_in) - D_W'(px_reg);
    assign dy = D_W'(cy_in) - D_W'(py_reg);
    assign dz = D_W'(cz_in) - D_W'(pz_reg);
    assign mx = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
    assign my = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    assign mz = dz[D_W-1] ? D_W'(-dz) : D_W'(dz);

    always_ff @(posedge clk)
    begin
        // new point comes straight from the held word, not from the chain
        if (wr_en)
        begin
            px_reg <= wx_in;
            py_reg <= wy_in;
            pz_reg <= wz_in;
        end
        cx_reg  <= cx_in;
        cy_reg  <= cy_in;
        cz_reg  <= cz_in;
        sqx_reg <= SQ_W'(mx * mx);
        sqy_reg <= SQ_W'(my * my);
        sqz_reg <= SQ_W'(mz * mz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            close_reg <= close_next;
            pend_reg  <= active;
        end
    end

    assign cx_out    = cx_reg;
    assign cy_out    = cy_reg;
    assign cz_out    = cz_reg;
    assign close_out = close_reg;
    assign pend_out  = pend_reg;
    assign sqx_out   = sqx_reg;
    assign sqy_out   = sqy_reg;
    assign sqz_out   = sqz_reg;
endmodule

// ===== tb/dtmd_scoreboard.sv =====
module dtmd_scoreboard
    import dtmd_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    dtmd_in_if   mon_in,
    dtmd_out_if  mon_out,
    dtmd_cfg_if  mon_cfg,
    output int   fail_count,
    output int   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        outcome_t           outcome;
        logic [INDEX_W-1:0] index;
        logic [QUOTA_W-1:0] total;
    } filter_result_t;

    // own copy of the point store and counters
    logic signed [COORD_BITS-1:0] px [STORE_DEPTH];
    logic signed [COORD_BITS-1:0] py [STORE_DEPTH];
    logic signed [COORD_BITS-1:0] pz [STORE_DEPTH];
    int                 points_held;
    int                 new_accepts;
    logic [THR_W-1:0]   radius_sq;
    logic [QUOTA_W-1:0] quota;

    filter_result_t pending_results[$];

    assign pending_count = pending_results.size();

    function automatic logic [63:0] dist_sq(input int k, input logic signed [COORD_BITS-1:0] x,
                                            input logic signed [COORD_BITS-1:0] y,
                                            input logic signed [COORD_BITS-1:0] z);
        longint dx, dy, dz;
        dx = longint'(x) - longint'(px[k]);
        dy = longint'(y) - longint'(py[k]);
        dz = longint'(z) - longint'(pz[k]);
        // at most three times 2^48, no saturation reachable
        return 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
    endfunction

    function automatic outcome_t predict_filter_outcome(input logic [1:0] req,
                                                       input logic signed [COORD_BITS-1:0] x,
                                                       input logic signed [COORD_BITS-1:0] y,
                                                       input logic signed [COORD_BITS-1:0] z);
        bit far;
        far = 1'b1;
        case (req)
            REQ_START:
            begin
                points_held = 0;
                new_accepts = 0;
                return OUT_CLEARED;
            end
            REQ_PRELOAD:
            begin
                if (points_held >= STORE_DEPTH)
                    return OUT_FULL;
                px[points_held] = x;
                py[points_held] = y;
                pz[points_held] = z;
                points_held++;
                return OUT_PRELOADED;
            end
            default:
            begin
                if (new_accepts >= int'(quota))
                    return OUT_QUOTA;
                for (int k = 0; k < points_held; k++)
                    if (dist_sq(k, x, y, z) < {12'd0, radius_sq})
                        far = 1'b0;
                if (!far)
                    return OUT_TOO_CLOSE;
                if (points_held >= STORE_DEPTH)
                    return OUT_FULL;
                px[points_held] = x;
                py[points_held] = y;
                pz[points_held] = z;
                points_held++;
                new_accepts++;
                return OUT_ACCEPTED;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t want;
        if (!rst_n)
        begin
            points_held = 0;
            new_accepts = 0;
            radius_sq   = '0;
            quota       = QUOTA_RESET;
            fail_count  = 0;
            pending_results.delete();
        end
        else
        begin
            if (mon_cfg.valid && mon_cfg.ready)
            begin
                if (mon_cfg.index == CFG_MIN_DIST_SQ)
                    radius_sq = mon_cfg.data;
                else
                    quota = mon_cfg.data[QUOTA_W-1:0];
            end
            if (mon_in.valid && mon_in.ready && mon_in.req_type != REQ_UNUSED)
            begin
                want.outcome = predict_filter_outcome(mon_in.req_type, mon_in.pos_x,
                                                      mon_in.pos_y, mon_in.pos_z);
                want.index   = mon_in.cand_index;
                want.total   = QUOTA_W'(new_accepts);
                pending_results.insert(pending_results.size(), want);
            end
            if (mon_out.valid && mon_out.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result word outcome %0d index %h", $time,
                             mon_out.outcome, mon_out.out_index);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (mon_out.outcome !== want.outcome)
                    begin
                        $display("%0t: outcome expected %0d actual %0d", $time,
                                 want.outcome, mon_out.outcome);
                        fail_count++;
                    end
                    if (mon_out.out_index !== want.index)
                    begin
                        $display("%0t: out_index expected %h actual %h", $time,
                                 want.index, mon_out.out_index);
                        fail_count++;
                    end
                    if (mon_out.accepted_total !== want.total)
                    begin
                        $display("%0t: accepted_total expected %0d actual %0d", $time,
                                 want.total, mon_out.accepted_total);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/dart_throwing_min_distance_filter_unit_tb.sv =====
module dart_throwing_min_distance_filter_unit_tb;
    import dtmd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = STORE_DEPTH_DEF;
    localparam int CB    = COORD_BITS_DEF;
    localparam int WORDS_WANTED = 1100;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;

    // when set, neither side inserts gaps
    bit   no_idle;
    int   words_sent;
    int   phases;

    dtmd_in_if #(.COORD_BITS(CB)) in_ch ();
    dtmd_out_if out_ch ();
    dtmd_cfg_if cfg_ch ();

    dart_throwing_min_distance_filter_unit #(
        .STORE_DEPTH(DEPTH),
        .COORD_BITS (CB)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .in   (in_ch),
        .out  (out_ch),
        .cfg  (cfg_ch)
    );

    dtmd_scoreboard #(
        .STORE_DEPTH(DEPTH),
        .COORD_BITS (CB)
    ) u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .mon_in       (in_ch),
        .mon_out      (out_ch),
        .mon_cfg      (cfg_ch),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // result side: hold ready low for a random stretch now and then
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            out_ch.ready <= (stall_left == 0);
        end
    end

    // valid stays high across back-to-back words, dropped only for a gap
    task automatic send_word(input req_t req, input logic [31:0] idx,
                             input logic [CB-1:0] x, input logic [CB-1:0] y,
                             input logic [CB-1:0] z);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= req;
        in_ch.cand_index <= idx;
        in_ch.pos_x      <= x;
        in_ch.pos_y      <= y;
        in_ch.pos_z      <= z;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // wait out every result, then a full sweep in case an ignored word is in flight
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [THR_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [THR_W-1:0] thr, input logic [QUOTA_W-1:0] q);
        drain();
        write_reg(CFG_MIN_DIST_SQ, thr);
        write_reg(CFG_ACCEPT_QUOTA, {{(THR_W-QUOTA_W){1'b0}}, q});
        phases++;
    endtask

    // point near a center, wrapping at the coordinate width
    function automatic logic [CB-1:0] near(input logic [CB-1:0] c, input int spread);
        return c + CB'($urandom_range(0, 2 * spread)) - CB'(spread);
    endfunction

    localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};

    initial
    begin
        logic [CB-1:0] cx, cy, cz;
        int            spread;
        int            k;
        int            shape;
        logic [THR_W-1:0] thr;
        logic [QUOTA_W-1:0] q;

        rst_n = 1'b0;
        no_idle = 1'b0;
        words_sent = 0;
        phases = 0;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_START;
        in_ch.cand_index = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_MIN_DIST_SQ;
        cfg_ch.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, empty store, identical points at zero radius
        send_word(REQ_CANDIDATE, 32'h0, CMIN, CMAX, '0);
        send_word(REQ_CANDIDATE, 32'hFFFF_FFFF, CMIN, CMAX, '0);
        send_word(REQ_UNUSED, 32'h1234_5678, CMAX, CMAX, CMAX);
        send_word(REQ_START, 32'hFFFF_FFFF, CMAX, CMIN, CMAX);

        // radius of exactly 10 raw units: distance equal passes, one less is too close
        set_regs(52'd100, 11'd1024);
        send_word(REQ_START, 32'd1, '0, '0, '0);
        send_word(REQ_PRELOAD, 32'd2, CMIN, CMIN, CMIN);
        send_word(REQ_PRELOAD, 32'd3, CMAX, CMAX, CMAX);
        send_word(REQ_CANDIDATE, 32'd4, CMIN + 24'd9, CMIN, CMIN);
        send_word(REQ_CANDIDATE, 32'd5, CMIN + 24'd10, CMIN, CMIN);
        send_word(REQ_CANDIDATE, 32'd6, CMAX, CMAX - 24'd6, CMAX - 24'd8);
        send_word(REQ_CANDIDATE, 32'd7, '0, '0, '0);

        // quota of two, then quota zero
        set_regs(52'd0, 11'd2);
        send_word(REQ_START, 32'd8, '0, '0, '0);
        send_word(REQ_CANDIDATE, 32'd9, '0, '0, '0);
        send_word(REQ_CANDIDATE, 32'd10, '0, '0, '0);
        send_word(REQ_CANDIDATE, 32'd11, '0, '0, '0);
        set_regs(52'd0, 11'd0);
        send_word(REQ_START, 32'd12, '0, '0, '0);
        send_word(REQ_CANDIDATE, 32'd13, CMAX, '0, CMIN);

        // largest radius: anything is too close once the store holds a point
        set_regs({THR_W{1'b1}}, 11'd1024);
        send_word(REQ_START, 32'd14, '0, '0, '0);
        send_word(REQ_CANDIDATE, 32'd15, CMIN, CMIN, CMIN);
        send_word(REQ_CANDIDATE, 32'd16, CMAX, CMAX, CMAX);

        // fill all but one slot with preloads, a candidate takes the last, then full on candidate and on preload
        set_regs(52'd0, 11'd1024);
        send_word(REQ_START, 32'd17, '0, '0, '0);
        no_idle = 1'b1;
        for (k = 0; k < DEPTH - 1; k++)
            send_word(REQ_PRELOAD, $urandom, $urandom, $urandom, $urandom);
        no_idle = 1'b0;
        send_word(REQ_CANDIDATE, 32'd18, $urandom, $urandom, $urandom);
        send_word(REQ_CANDIDATE, 32'd19, $urandom, $urandom, $urandom);
        send_word(REQ_PRELOAD, 32'd20, $urandom, $urandom, $urandom);

        // random phases: clustered points with radius scaled to the cluster
        while (words_sent < WORDS_WANTED)
        begin
            spread = 1 << $urandom_range(0, 23);
            shape = $urandom_range(0, 9);
            case (shape)
                0: thr = '0;
                1: thr = {THR_W{1'b1}};
                2: thr = {$urandom, $urandom} & {THR_W{1'b1}};
                default: thr = THR_W'(longint'(spread) * longint'(spread)
                               * longint'($urandom_range(0, 300)) / 100);
            endcase
            shape = $urandom_range(0, 9);
            case (shape)
                0: q = '0;
                1: q = 11'd1;
                2: q = 11'd1024;
                3: q = 11'($urandom_range(0, 1024));
                default: q = 11'($urandom_range(2, 30));
            endcase
            set_regs(thr, q);
            no_idle = ($urandom_range(0, 4) == 0);
            cx = $urandom;
            cy = $urandom;
            cz = $urandom;
            send_word(REQ_START, $urandom, $urandom, $urandom, $urandom);
            repeat ($urandom_range(0, 6))
                send_word(REQ_PRELOAD, $urandom, near(cx, spread), near(cy, spread),
                          near(cz, spread));
            repeat ($urandom_range(5, 35))
            begin
                shape = $urandom_range(0, 99);
                if (shape < 2)
                    send_word(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
                else if (shape < 4)
                    send_word(REQ_START, $urandom, $urandom, $urandom, $urandom);
                else if (shape < 8)
                    send_word(REQ_PRELOAD, $urandom, near(cx, spread), near(cy, spread),
                              near(cz, spread));
                else if (shape < 12)
                    send_word(REQ_CANDIDATE, $urandom, $urandom, $urandom, $urandom);
                else
                    send_word(REQ_CANDIDATE, $urandom, near(cx, spread), near(cy, spread),
                              near(cz, spread));
            end
        end

        no_idle = 1'b0;
        drain();
        $display("run covered %0d words over %0d register settings", words_sent, phases);
        $display("including directed radius, quota and full-store cases");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("timeout waiting for the block");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
